@@ design/bdcs_pkg.sv @@
package bdcs_pkg;

    localparam int unsigned BLOCK_COUNT = 1024;
    localparam int unsigned BLOCK_CHARS = 64;
    localparam int unsigned PLANES      = 3;
    localparam int unsigned MAX_LEN     = 65536;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned LEN_W  = 17;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CODE_W = 3;
    localparam int unsigned OFF_W  = $clog2(BLOCK_CHARS);
    localparam int unsigned BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    localparam int unsigned RAW_CAP = BLOCK_COUNT * BLOCK_CHARS;
    localparam logic [LEN_W-1:0] CAPACITY =
        LEN_W'((RAW_CAP > MAX_LEN) ? MAX_LEN : RAW_CAP);

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_CAPACITY = 2'd2;

    localparam logic [CODE_W-1:0] CODE_A = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T = 3'd3;
    localparam logic [CODE_W-1:0] CODE_N = 3'd4;

    typedef logic [PLANES-1:0][BLOCK_CHARS-1:0] t_word;

    localparam t_word ALL_N = {{BLOCK_CHARS{1'b1}}, {BLOCK_CHARS{1'b0}}, {BLOCK_CHARS{1'b0}}};

    typedef enum logic [1:0] {
        PATH_DONE,
        PATH_READ,
        PATH_RMW,
        PATH_WALK
    } t_path;

    typedef struct packed {
        logic in_ready;
        logic evaluate;
        logic read_done;
        logic rmw_write;
        logic walk_step;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic  req_fire;
        t_path path;
        logic  walk_last;
        logic  out_free;
    } t_sts;

    function automatic logic [CODE_W-1:0] encode(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            "A", "a": code = CODE_A;
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:  code = CODE_N;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] decode(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            CODE_A:  ch = "A";
            CODE_C:  ch = "C";
            CODE_G:  ch = "G";
            CODE_T:  ch = "T";
            default: ch = "N";
        endcase
        return ch;
    endfunction

    function automatic t_word merge(input t_word w, input logic [OFF_W-1:0] off,
                                    input logic [CODE_W-1:0] code);
        t_word r;
        r = w;
        r[0][off] = code[0];
        r[1][off] = code[1];
        r[2][off] = code[2];
        return r;
    endfunction

endpackage

@@ design/bdcs_ifs.sv @@
interface bdcs_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic [bdcs_pkg::POS_W-1:0]      position;
    logic [bdcs_pkg::CHAR_W-1:0]     character;

    modport source(output valid, command, position, character, input ready);
    modport sink(input valid, command, position, character, output ready);
endinterface

interface bdcs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bdcs_pkg::CHAR_W-1:0]     char_out;
    logic [bdcs_pkg::LEN_W-1:0]      string_length;
    logic [bdcs_pkg::STAT_W-1:0]     status;

    modport source(output valid, char_out, string_length, status, input ready);
    modport sink(input valid, char_out, string_length, status, output ready);
endinterface

@@ design/bdcs_ctrl.sv @@
module bdcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdcs_pkg::t_sts  i_sts,
    output bdcs_pkg::t_ctl  o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_RMW,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.req_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_sts.path)
                    bdcs_pkg::PATH_READ: n_state = S_READ;
                    bdcs_pkg::PATH_RMW:  n_state = S_RMW;
                    bdcs_pkg::PATH_WALK: n_state = S_WALK;
                    default:             n_state = S_FINISH;
                endcase
            end
            S_READ: n_state = S_FINISH;
            S_RMW:  n_state = S_FINISH;
            S_WALK: begin
                if (i_sts.walk_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl.in_ready  = (r_state == S_IDLE);
        o_ctl.evaluate  = (r_state == S_EVAL);
        o_ctl.read_done = (r_state == S_READ);
        o_ctl.rmw_write = (r_state == S_RMW);
        o_ctl.walk_step = (r_state == S_WALK);
        o_ctl.load_out  = (r_state == S_FINISH) && i_sts.out_free;
    end

endmodule

@@ design/bdcs_dpath.sv @@
module bdcs_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdcs_pkg::t_ctl  i_ctl,
    output bdcs_pkg::t_sts  o_sts,
    bdcs_req_if.sink        i_req,
    bdcs_rsp_if.source      o_rsp
);

    localparam int unsigned BLK_W = bdcs_pkg::BLK_W;
    localparam int unsigned LEN_W = bdcs_pkg::LEN_W;
    localparam int unsigned OFF_W = bdcs_pkg::OFF_W;

    bdcs_pkg::t_word r_mem [bdcs_pkg::BLOCK_COUNT];
    bdcs_pkg::t_word r_rdata;

    bdcs_pkg::t_cmd                   r_cmd;
    logic [bdcs_pkg::POS_W-1:0]       r_pos;
    logic [bdcs_pkg::CHAR_W-1:0]      r_char;
    logic [LEN_W-1:0]                 r_len;
    logic [LEN_W-1:0]                 r_eff;
    logic [BLK_W-1:0]                 r_blk;
    logic [OFF_W-1:0]                 r_off;
    logic [bdcs_pkg::CODE_W-1:0]      r_code;
    logic [BLK_W:0]                   r_walk;
    logic                             r_extend;
    logic [bdcs_pkg::CHAR_W-1:0]      r_char_out;
    logic [bdcs_pkg::STAT_W-1:0]      r_status;
    logic                             r_ovalid;
    logic [bdcs_pkg::CHAR_W-1:0]      r_o_char;
    logic [LEN_W-1:0]                 r_o_len;
    logic [bdcs_pkg::STAT_W-1:0]      r_o_status;

    logic                             req_fire;
    logic                             is_put;
    logic [LEN_W-1:0]                 eff;
    logic                             cap_err;
    logic                             rd_err;
    logic                             extend;
    logic [BLK_W-1:0]                 blk_c;
    logic [BLK_W:0]                   first_new;
    logic                             new_blk;
    bdcs_pkg::t_path                  path;
    logic                             walk_last;
    logic                             wr_en;
    logic [BLK_W-1:0]                 wr_addr;
    bdcs_pkg::t_word                  wr_data;
    logic [bdcs_pkg::CODE_W-1:0]      rd_code;

    assign i_req.ready = i_ctl.in_ready && i_rst_n;
    assign req_fire    = i_req.valid && i_req.ready;

    always_comb begin
        is_put    = (r_cmd == bdcs_pkg::CMD_WRITE) || (r_cmd == bdcs_pkg::CMD_APPEND);
        eff       = (r_cmd == bdcs_pkg::CMD_APPEND) ? r_len : {1'b0, r_pos};
        cap_err   = is_put && (eff >= bdcs_pkg::CAPACITY);
        rd_err    = (r_cmd == bdcs_pkg::CMD_READ) && ({1'b0, r_pos} >= r_len);
        extend    = (eff >= r_len);
        blk_c     = BLK_W'(eff >> OFF_W);
        first_new = (BLK_W + 1)'((r_len + LEN_W'(bdcs_pkg::BLOCK_CHARS - 1)) >> OFF_W);
        new_blk   = extend && (first_new <= {1'b0, blk_c});
        if ((r_cmd == bdcs_pkg::CMD_CLEAR) || cap_err || rd_err) begin
            path = bdcs_pkg::PATH_DONE;
        end else if (r_cmd == bdcs_pkg::CMD_READ) begin
            path = bdcs_pkg::PATH_READ;
        end else if (new_blk) begin
            path = bdcs_pkg::PATH_WALK;
        end else begin
            path = bdcs_pkg::PATH_RMW;
        end
    end

    assign walk_last = (r_walk == {1'b0, r_blk});
    assign wr_en     = i_ctl.rmw_write || i_ctl.walk_step;
    assign wr_addr   = i_ctl.rmw_write ? r_blk : r_walk[BLK_W-1:0];

    always_comb begin
        if (i_ctl.rmw_write) begin
            wr_data = bdcs_pkg::merge(r_rdata, r_off, r_code);
        end else if (walk_last) begin
            wr_data = bdcs_pkg::merge(bdcs_pkg::ALL_N, r_off, r_code);
        end else begin
            wr_data = bdcs_pkg::ALL_N;
        end
    end

    assign rd_code = {r_rdata[2][r_off], r_rdata[1][r_off], r_rdata[0][r_off]};

    always_comb begin
        o_sts.req_fire  = req_fire;
        o_sts.path      = path;
        o_sts.walk_last = walk_last;
        o_sts.out_free  = !r_ovalid || o_rsp.ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.evaluate) begin
            r_rdata <= r_mem[blk_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_cmd  <= bdcs_pkg::t_cmd'(i_req.command);
            r_pos  <= i_req.position;
            r_char <= i_req.character;
        end
        if (i_ctl.evaluate) begin
            r_eff      <= eff;
            r_blk      <= blk_c;
            r_off      <= eff[OFF_W-1:0];
            r_code     <= bdcs_pkg::encode(r_char);
            r_extend   <= extend;
            r_walk     <= first_new;
            r_char_out <= '0;
            if (cap_err) begin
                r_status <= bdcs_pkg::ST_CAPACITY;
            end else if (rd_err) begin
                r_status <= bdcs_pkg::ST_RANGE;
            end else begin
                r_status <= bdcs_pkg::ST_OK;
            end
        end
        if (i_ctl.walk_step) begin
            r_walk <= r_walk + 1'b1;
        end
        if (i_ctl.read_done) begin
            r_char_out <= bdcs_pkg::decode(rd_code);
        end
        if (i_ctl.load_out) begin
            r_o_char   <= r_char_out;
            r_o_len    <= r_len;
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.evaluate && (r_cmd == bdcs_pkg::CMD_CLEAR)) begin
                r_len <= '0;
            end else if ((i_ctl.rmw_write && r_extend) || (i_ctl.walk_step && walk_last)) begin
                r_len <= r_eff + 1'b1;
            end
            if (i_ctl.load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.char_out      = r_o_char;
    assign o_rsp.string_length = r_o_len;
    assign o_rsp.status        = r_o_status;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= bdcs_pkg::CAPACITY)
        else $error("Stored length exceeds capacity.");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.walk_step |-> (r_walk <= {1'b0, r_blk}))
        else $error("Block initialization walked past the target block.");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.evaluate && (r_cmd == bdcs_pkg::CMD_CLEAR)) |=> (r_len == '0))
        else $error("Clear did not reset the length.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |-> (!r_ovalid || o_rsp.ready))
        else $error("Result loaded over one that was not taken.");
`endif

endmodule

@@ design/bitplane_dna_char_store.sv @@
// Stores a DNA string of up to 65536 characters as 3-bit codes in three bit planes,
// one 192-bit memory word per block of 64 characters.
// The request channel carries command, position and character; the response channel
// returns char_out, string_length and status, one response for each request.
// A request is taken only while the block is idle. A read, or a write inside an existing
// block, passes through these steps after acceptance: decode and issue the block read,
// write back or decode with the registered read data, load the response register, and
// return to idle, where the next request can be taken. Clear and rejected requests skip
// the second step. A write that reaches new blocks instead writes each new block as all
// N, one memory write per cycle, with the character merged into the last of them.
// The response is valid from the return to idle on and stays in its output
// register while the receiver stalls; the next request is accepted meanwhile, and its
// result waits in the finishing step until the output register is free.
// Reset empties the string and holds the request ready low. The block memory itself is
// not cleared; every block is written to all N before any character in it can be read.
module bitplane_dna_char_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdcs_req_if.sink    i_req,
    bdcs_rsp_if.source  o_rsp
);

    bdcs_pkg::t_ctl ctl;
    bdcs_pkg::t_sts sts;

    bdcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    bdcs_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [bdcs_pkg::CHAR_W-1:0] LETTERS [8] =
        '{"A", "C", "G", "T", "a", "c", "g", "t"};

    typedef struct {
        bdcs_pkg::t_cmd              cmd;
        logic [bdcs_pkg::POS_W-1:0]  pos;
        logic [bdcs_pkg::CHAR_W-1:0] ch;
        bit                          drain;
    } t_request;

    typedef struct {
        logic [bdcs_pkg::CHAR_W-1:0] ch;
        logic [bdcs_pkg::LEN_W-1:0]  len;
        logic [bdcs_pkg::STAT_W-1:0] st;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    bdcs_req_if req_if();
    bdcs_rsp_if rsp_if();

    bitplane_dna_char_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    bdcs_pkg::t_word            plane_store [bdcs_pkg::BLOCK_COUNT];
    logic [bdcs_pkg::LEN_W-1:0] stored_chars;
    logic [bdcs_pkg::LEN_W-1:0] planned_chars;

    t_request commands_waiting [$];
    t_result  replies_due [$];

    int errors;
    int requests_taken;
    int total_items;
    int quiet_cycles;

    function automatic logic [bdcs_pkg::CODE_W-1:0] char_code(
            logic [bdcs_pkg::CHAR_W-1:0] ch);
        logic [bdcs_pkg::CODE_W-1:0] code;
        case (ch | 8'h20)
            "a":     code = bdcs_pkg::CODE_A;
            "c":     code = bdcs_pkg::CODE_C;
            "g":     code = bdcs_pkg::CODE_G;
            "t":     code = bdcs_pkg::CODE_T;
            default: code = bdcs_pkg::CODE_N;
        endcase
        return code;
    endfunction

    function automatic logic [bdcs_pkg::LEN_W-1:0] grown_length(
            logic [bdcs_pkg::LEN_W-1:0] len, bdcs_pkg::t_cmd cmd,
            logic [bdcs_pkg::POS_W-1:0] pos);
        logic [bdcs_pkg::LEN_W-1:0] next;
        next = len;
        case (cmd)
            bdcs_pkg::CMD_WRITE: begin
                if ({1'b0, pos} < bdcs_pkg::CAPACITY && {1'b0, pos} >= len) begin
                    next = {1'b0, pos} + 1'b1;
                end
            end
            bdcs_pkg::CMD_APPEND: begin
                if (len < bdcs_pkg::CAPACITY) begin
                    next = len + 1'b1;
                end
            end
            bdcs_pkg::CMD_CLEAR: next = '0;
            default:             next = len;
        endcase
        return next;
    endfunction

    function automatic t_result dna_store_step(t_request r);
        t_result                     res;
        logic [bdcs_pkg::LEN_W-1:0]  target;
        logic [bdcs_pkg::CODE_W-1:0] code;
        int unsigned                 blk;
        int unsigned                 off;
        int unsigned                 b;
        int unsigned                 p;
        int unsigned                 first_new;
        res.ch = '0;
        res.st = bdcs_pkg::ST_OK;
        target = (r.cmd == bdcs_pkg::CMD_APPEND) ? stored_chars : {1'b0, r.pos};
        blk = target / bdcs_pkg::BLOCK_CHARS;
        off = target % bdcs_pkg::BLOCK_CHARS;
        case (r.cmd)
            bdcs_pkg::CMD_WRITE, bdcs_pkg::CMD_APPEND: begin
                if (target >= bdcs_pkg::CAPACITY) begin
                    res.st = bdcs_pkg::ST_CAPACITY;
                end else begin
                    if (target >= stored_chars) begin
                        first_new = (stored_chars > 0)
                            ? (stored_chars - 1) / bdcs_pkg::BLOCK_CHARS + 1 : 1;
                        for (b = first_new; b <= blk; b++) begin
                            plane_store[b] = bdcs_pkg::ALL_N;
                        end
                    end
                    code = char_code(r.ch);
                    for (p = 0; p < bdcs_pkg::PLANES; p++) begin
                        plane_store[blk][p][off] = code[p];
                    end
                end
            end
            bdcs_pkg::CMD_READ: begin
                if (target >= stored_chars) begin
                    res.st = bdcs_pkg::ST_RANGE;
                end else begin
                    code = {plane_store[blk][2][off], plane_store[blk][1][off],
                            plane_store[blk][0][off]};
                    res.ch = code[2] ? "N" : LETTERS[code[1:0]];
                end
            end
            default: plane_store[0] = bdcs_pkg::ALL_N;
        endcase
        stored_chars = grown_length(stored_chars, r.cmd, r.pos);
        res.len = stored_chars;
        return res;
    endfunction

    task automatic queue_command(bdcs_pkg::t_cmd cmd, logic [bdcs_pkg::POS_W-1:0] pos,
                                 logic [bdcs_pkg::CHAR_W-1:0] ch, bit drain);
        t_request r;
        r.cmd = cmd;
        r.pos = pos;
        r.ch = ch;
        r.drain = drain;
        commands_waiting.push_back(r);
        planned_chars = grown_length(planned_chars, cmd, pos);
    endtask

    task automatic queue_random_command(bit drain);
        bdcs_pkg::t_cmd              cmd;
        logic [bdcs_pkg::POS_W-1:0]  pos;
        logic [bdcs_pkg::CHAR_W-1:0] ch;
        int unsigned                 roll;
        int unsigned                 span;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            cmd = bdcs_pkg::CMD_WRITE;
        end else if (roll < 55) begin
            cmd = bdcs_pkg::CMD_APPEND;
        end else if (roll < 96) begin
            cmd = bdcs_pkg::CMD_READ;
        end else begin
            cmd = bdcs_pkg::CMD_CLEAR;
        end
        roll = $urandom_range(0, 99);
        span = planned_chars + 130;
        if (span > 65535) begin
            span = 65535;
        end
        if (roll < 3) begin
            pos = bdcs_pkg::POS_W'($urandom_range(0, 65535));
        end else if (roll < 25 || planned_chars == 0) begin
            pos = bdcs_pkg::POS_W'($urandom_range(0, span));
        end else begin
            pos = bdcs_pkg::POS_W'($urandom_range(0, planned_chars - 1));
        end
        if ($urandom_range(0, 99) < 70) begin
            ch = LETTERS[$urandom_range(0, 7)];
        end else begin
            ch = bdcs_pkg::CHAR_W'($urandom_range(0, 255));
        end
        queue_command(cmd, pos, ch, drain || ($urandom_range(0, 99) == 0));
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
        errors++;
    endtask

    function automatic int sender_idle_pct();
        if (requests_taken * 3 < total_items) begin
            return 34;
        end else if (requests_taken * 3 < total_items * 2) begin
            return 85;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (requests_taken * 3 < total_items) begin
            return 85;
        end else if (requests_taken * 3 < total_items * 2) begin
            return 34;
        end
        return 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.command = bdcs_pkg::CMD_READ;
        req_if.position = '0;
        req_if.character = '0;
        rsp_if.ready = 1'b0;
        errors = 0;
        requests_taken = 0;
        quiet_cycles = 0;
        stored_chars = '0;
        planned_chars = '0;
        foreach (plane_store[i]) begin
            plane_store[i] = '0;
        end
        plane_store[0] = bdcs_pkg::ALL_N;

        queue_command(bdcs_pkg::CMD_READ, 16'd0, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'hFFFF, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "c", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "G", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "t", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "x", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, 8'h00, 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, 8'hFF, 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd0, 8'hFF, 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd1, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd4, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_WRITE, 16'd2, "T", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd2, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd7, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_WRITE, 16'd200, "g", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd150, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd200, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_WRITE, 16'hFFFF, "C", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'hFFFF, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'hFFFE, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_CLEAR, 16'hFFFF, "G", 1'b1);
        queue_command(bdcs_pkg::CMD_READ, 16'd0, "A", 1'b0);
        queue_command(bdcs_pkg::CMD_APPEND, 16'd0, "T", 1'b0);
        queue_command(bdcs_pkg::CMD_READ, 16'd0, "A", 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            queue_random_command(i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3);
        end
        total_items = commands_waiting.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (commands_waiting.size() != 0 || replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        logic                        show;
        logic [1:0]                  cmd;
        logic [bdcs_pkg::POS_W-1:0]  pos;
        logic [bdcs_pkg::CHAR_W-1:0] ch;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            show = req_if.valid;
            cmd = req_if.command;
            pos = req_if.position;
            ch = req_if.character;
            if (req_if.valid && req_if.ready) begin
                replies_due.push_back(dna_store_step(commands_waiting.pop_front()));
                requests_taken++;
                show = 1'b0;
            end
            if (!show) begin
                cmd = 2'($urandom_range(0, 3));
                pos = bdcs_pkg::POS_W'($urandom_range(0, 65535));
                ch = bdcs_pkg::CHAR_W'($urandom_range(0, 255));
                if (commands_waiting.size() != 0
                        && !(commands_waiting[0].drain && replies_due.size() != 0)
                        && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    show = 1'b1;
                    cmd = commands_waiting[0].cmd;
                    pos = commands_waiting[0].pos;
                    ch = commands_waiting[0].ch;
                end
            end
            req_if.valid <= show;
            req_if.command <= cmd;
            req_if.position <= pos;
            req_if.character <= ch;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (replies_due.size() == 0) begin
                    report("response with no request outstanding", 32'(rsp_if.status), 32'd0);
                end else begin
                    want = replies_due.pop_front();
                    if (rsp_if.char_out !== want.ch) begin
                        report("char_out", 32'(rsp_if.char_out), 32'(want.ch));
                    end
                    if (rsp_if.string_length !== want.len) begin
                        report("string_length", 32'(rsp_if.string_length), 32'(want.len));
                    end
                    if (rsp_if.status !== want.st) begin
                        report("status", 32'(rsp_if.status), 32'(want.st));
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
design/bdcs_pkg.sv
design/bdcs_ifs.sv
design/bdcs_ctrl.sv
design/bdcs_dpath.sv
design/bitplane_dna_char_store.sv
tb/testbench.sv
